>>> sv/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg: shared types and constants of the delimited message framer
// Request and result payloads, the internal command format, register
// indexes and verdict codes.
// ----------------------------------------------------------------------------
package dmf_pkg;

    // Smallest timeout the timer will honor, in ticks
    localparam logic [15:0] MIN_TIMEOUT_TICKS = 16'd10;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BYTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_LEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_BYTES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

    // Request kinds
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_RELEASE = 2'd1,
        VERDICT_DROP    = 2'd2
    } verdict_t;

    // Input request payload
    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       chunk_end;
    } dmf_in_t;

    // Result payload
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [9:0]  byte_index;
        verdict_t    verdict;
        logic [10:0] message_length;
    } dmf_out_t;

    // Classified request as queued between front and back
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
        logic       last;
    } dmf_cmd_t;

    // Configuration write bundle
    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } dmf_cfg_wr_t;

endpackage

>>> sv/dmf_front.sv
// ----------------------------------------------------------------------------
// dmf_front: request intake
// Registers each accepted request and classifies it into a data or tick
// command, scrubbing fields that do not apply to the kind.
// ----------------------------------------------------------------------------
module dmf_front import dmf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dmf_in_t  s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output dmf_cmd_t cmd
);

    logic     vld_reg, vld_next;
    dmf_cmd_t cmd_reg, cmd_next;
    logic     take;

    // Free when empty or when the held command moves on this cycle
    assign s_ready = !vld_reg || cmd_ready;
    assign take    = s_valid && s_ready;

    // Classification
    always_comb begin
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (take) begin
            vld_next         = 1'b1;
            cmd_next.is_tick = (s_data.req_type == REQ_TICK);
            cmd_next.data    = (s_data.req_type == REQ_TICK) ? 8'd0 : s_data.data_byte;
            cmd_next.last    = (s_data.req_type == REQ_DATA) && s_data.chunk_end;
        end else if (cmd_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

endmodule

>>> sv/dmf_queue.sv
// ----------------------------------------------------------------------------
// dmf_queue: two-entry command queue
// Decouples intake from message processing so either side can stall alone.
// ----------------------------------------------------------------------------
module dmf_queue import dmf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dmf_cmd_t in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output dmf_cmd_t out_cmd
);

    dmf_cmd_t   slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> sv/dmf_back.sv
// ----------------------------------------------------------------------------
// dmf_back: message state and result generation
// Holds the configuration and the running message, applies one command per
// cycle unless the output register is stalled, and presents the result there.
// ----------------------------------------------------------------------------
module dmf_back import dmf_pkg::*; #(
    parameter int BUFFER_BYTES     = 1024,
    parameter int MAX_MARKER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dmf_cfg_wr_t cfg,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  dmf_cmd_t    cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output dmf_out_t    m_data
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int XW = (CW > 11) ? CW : 11;
    localparam logic [3:0] MAX_LEN = 4'(MAX_MARKER_BYTES);

    // Configuration
    logic [3:0]  prefix_len_reg, suffix_len_reg;
    logic [63:0] prefix_bytes_reg, suffix_bytes_reg;
    logic [15:0] timeout_ticks_reg;

    // Message state
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [63:0]   head_reg, head_next;
    logic [63:0]   tail_reg, tail_next;
    logic [15:0]   timer_reg, timer_next;
    logic          running_reg, running_next;

    // Output register
    logic     out_vld_reg, out_vld_next;
    dmf_out_t out_reg, out_next;

    logic          pop;
    logic [CW-1:0] cnt_inc;
    logic [63:0]   head_new, tail_new;
    logic [3:0]    n_pre, n_suf;
    logic          pre_ok, suf_ok, release_msg;
    logic [15:0]   limit, timer_inc;
    logic [XW-1:0] idx_ext, len_ext;

    function automatic logic [3:0] clamp_len(input logic [3:0] n);
        return (n > MAX_LEN) ? MAX_LEN : n;
    endfunction

    assign cmd_ready = !out_vld_reg || m_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_len_reg    <= 4'd0;
            prefix_bytes_reg  <= 64'd0;
            suffix_len_reg    <= 4'd0;
            suffix_bytes_reg  <= 64'd0;
            timeout_ticks_reg <= MIN_TIMEOUT_TICKS;
        end else if (cfg.wr_en) begin
            case (cfg.index)
                REG_PREFIX_LEN:    prefix_len_reg    <= cfg.wdata[3:0];
                REG_PREFIX_BYTES:  prefix_bytes_reg  <= cfg.wdata;
                REG_SUFFIX_LEN:    suffix_len_reg    <= cfg.wdata[3:0];
                REG_SUFFIX_BYTES:  suffix_bytes_reg  <= cfg.wdata;
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.wdata[15:0];
                default: ;
            endcase
        end
    end

    // Marker capture and matching for the incoming byte
    always_comb begin
        logic [2:0] sel;
        cnt_inc  = byte_count_reg + CW'(1);
        head_new = head_reg;
        for (int i = 0; i < 8; i++) begin
            if (i < MAX_MARKER_BYTES && byte_count_reg == CW'(i)) begin
                head_new[8*i +: 8] = cmd.data;
            end
        end
        tail_new = {tail_reg[55:0], cmd.data};
        n_pre    = clamp_len(prefix_len_reg);
        n_suf    = clamp_len(suffix_len_reg);

        pre_ok = (cnt_inc >= CW'(n_pre));
        suf_ok = (cnt_inc >= CW'(n_suf));
        for (int i = 0; i < 8; i++) begin
            sel = 3'(n_suf - 4'd1 - 4'(i));
            if (4'(i) < n_pre && head_new[8*i +: 8] != prefix_bytes_reg[8*i +: 8]) begin
                pre_ok = 1'b0;
            end
            if (4'(i) < n_suf && tail_new[8*sel +: 8] != suffix_bytes_reg[8*i +: 8]) begin
                suf_ok = 1'b0;
            end
        end

        // Chunk-end release rule, overridden by the buffer limit
        release_msg = 1'b0;
        if (cnt_inc >= CW'(BUFFER_BYTES)) begin
            release_msg = 1'b1;
        end else if (cmd.last) begin
            case ({prefix_len_reg != 4'd0, suffix_len_reg != 4'd0})
                2'b00:   release_msg = 1'b1;
                2'b10:   release_msg = pre_ok;
                2'b01:   release_msg = suf_ok;
                default: release_msg = pre_ok && suf_ok;
            endcase
        end
    end

    assign limit     = (timeout_ticks_reg < MIN_TIMEOUT_TICKS) ? MIN_TIMEOUT_TICKS
                                                               : timeout_ticks_reg;
    assign timer_inc = timer_reg + 16'd1;
    assign idx_ext   = XW'(byte_count_reg);
    assign len_ext   = XW'(cmd.is_tick ? byte_count_reg : cnt_inc);

    // Command execution
    always_comb begin
        byte_count_next = byte_count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        timer_next      = timer_reg;
        running_next    = running_reg;
        out_vld_next    = out_vld_reg;
        out_next        = out_reg;
        if (m_ready) begin
            out_vld_next = 1'b0;
        end
        if (pop) begin
            out_vld_next            = 1'b1;
            out_next                = '0;
            out_next.verdict        = VERDICT_NONE;
            if (!cmd.is_tick) begin
                out_next.byte_out   = cmd.data;
                out_next.byte_index = idx_ext[9:0];
                byte_count_next     = cnt_inc;
                head_next           = head_new;
                tail_next           = tail_new;
                if (!running_reg) begin
                    running_next = 1'b1;
                    timer_next   = 16'd0;
                end
                if (release_msg) begin
                    out_next.verdict        = VERDICT_RELEASE;
                    out_next.message_length = len_ext[10:0];
                    byte_count_next = '0;
                    head_next       = '0;
                    tail_next       = '0;
                    timer_next      = 16'd0;
                    running_next    = 1'b0;
                end
            end else if (running_reg) begin
                timer_next = timer_inc;
                if (timer_inc >= limit) begin
                    out_next.verdict        = VERDICT_DROP;
                    out_next.message_length = len_ext[10:0];
                    byte_count_next = '0;
                    head_next       = '0;
                    tail_next       = '0;
                    timer_next      = 16'd0;
                    running_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            timer_reg      <= 16'd0;
            running_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            timer_reg      <= timer_next;
            running_reg    <= running_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

>>> sv/delimited_message_framer_core.sv
// ----------------------------------------------------------------------------
// delimited_message_framer_core: byte stream to message framer
// Echoes received bytes with their message position and releases or drops
// messages by marker match, buffer limit or tick timeout.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry requests: a data byte (with chunk_end on
//   the last byte of a chunk) or a one millisecond tick. m_valid/m_ready/
//   m_data return exactly one result per request, in order.
//   cfg_wr_en/cfg_index/cfg_wdata write the marker and timeout registers;
//   write only while no request is in flight.
//   Path: an accepted request passes the intake register, the queue and
//   the result register, in that order, before its result shows on m_valid.
//   Throughput: one request per cycle while the receiver keeps m_ready high,
//   set by the back end's update of the message state and marker compare.
//   Reset clears the markers, sets the timeout to 10 ticks, empties the
//   message buffer and stops the timer.
//   When the receiver stalls, the result register holds, the two-entry
//   queue and the intake register fill, and then s_ready drops.
// ----------------------------------------------------------------------------
module delimited_message_framer_core import dmf_pkg::*; #(
    parameter int BUFFER_BYTES     = 1024,
    parameter int MAX_MARKER_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dmf_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dmf_out_t              m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic        f_valid, f_ready;
    dmf_cmd_t    f_cmd;
    logic        q_valid, q_ready;
    dmf_cmd_t    q_cmd;
    dmf_cfg_wr_t cfg;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    dmf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    dmf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    dmf_back #(
        .BUFFER_BYTES     (BUFFER_BYTES),
        .MAX_MARKER_BYTES (MAX_MARKER_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> sv/dmf_checker.sv
// ----------------------------------------------------------------------------
// dmf_checker: port-level checks of the framer
// Watches the result channel for reset behavior, stall hold and consistency
// of the verdict with the other result fields.
// ----------------------------------------------------------------------------
module dmf_checker import dmf_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input dmf_out_t m_data
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // No length unless a message is released or dropped
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict == VERDICT_NONE |-> m_data.message_length == 11'd0)
        else $error("length reported without a verdict");

    // A drop comes only from a tick, which echoes nothing
    a_drop_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict == VERDICT_DROP
            |-> m_data.byte_out == 8'd0 && m_data.byte_index == 10'd0)
        else $error("drop result carries an echoed byte");

    // A release on a byte covers at least that byte
    a_release_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict == VERDICT_RELEASE |-> m_data.message_length != 11'd0
            || m_data.byte_index == 10'd1023)
        else $error("release with empty message");

endmodule

bind delimited_message_framer_core dmf_checker u_dmf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
